// ----- design/iprc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprc_pkg
// Shared types, constants and command codes for the interval partition
// resource counter.
// ----------------------------------------------------------------------------
package iprc_pkg;

  localparam int MaxItemsDefault = 1024;
  localparam int SecPerMin       = 60;
  localparam int TimeW           = 17;
  localparam int KeyW            = 2 * TimeW;
  localparam int ResultW         = 11;

  localparam int CmdW = 4;
  localparam logic [CmdW-1:0] CMD_NONE     = 4'd0;
  localparam logic [CmdW-1:0] CMD_LOAD     = 4'd1;
  localparam logic [CmdW-1:0] CMD_INS_RD   = 4'd2;
  localparam logic [CmdW-1:0] CMD_INS_MOVE = 4'd3;
  localparam logic [CmdW-1:0] CMD_INS_PUT  = 4'd4;
  localparam logic [CmdW-1:0] CMD_SW_START = 4'd5;
  localparam logic [CmdW-1:0] CMD_SW_RD    = 4'd6;
  localparam logic [CmdW-1:0] CMD_SW_HIT   = 4'd7;
  localparam logic [CmdW-1:0] CMD_SW_NEW   = 4'd8;
  localparam logic [CmdW-1:0] CMD_ADD_RD   = 4'd9;
  localparam logic [CmdW-1:0] CMD_ADD_MOVE = 4'd10;
  localparam logic [CmdW-1:0] CMD_ADD_PUT  = 4'd11;
  localparam logic [CmdW-1:0] CMD_REM_RD   = 4'd12;
  localparam logic [CmdW-1:0] CMD_REM_MOVE = 4'd13;
  localparam logic [CmdW-1:0] CMD_REM_PUT  = 4'd14;
  localparam logic [CmdW-1:0] CMD_CLEAR    = 4'd15;

  typedef struct packed {
    logic full;
    logic j_zero;
    logic j_eq_used;
    logic i_eq_cnt;
    logic used_zero;
    logic s_gt_key;
    logic b_le_st;
    logic b_gt_en;
    logic b_le_en;
  } status_t;

  function automatic logic [TimeW-1:0] to_seconds(input logic [4:0] h,
                                                  input logic [5:0] m,
                                                  input logic [5:0] s);
    logic [TimeW-1:0] hm;
    hm = TimeW'(h) * TimeW'(SecPerMin) + TimeW'(m);
    return hm * TimeW'(SecPerMin) + TimeW'(s);
  endfunction

endpackage

// ----- design/iprc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprc_datapath
// Sorted interval store, sorted busy-until list, counters and compares.
// ----------------------------------------------------------------------------
module iprc_datapath #(
  parameter int MAX_ITEMS = iprc_pkg::MaxItemsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [iprc_pkg::CmdW-1:0]     cmd,
  input  logic [4:0]                    start_hour,
  input  logic [5:0]                    start_minute,
  input  logic [5:0]                    start_second,
  input  logic [4:0]                    end_hour,
  input  logic [5:0]                    end_minute,
  input  logic [5:0]                    end_second,
  output iprc_pkg::status_t             status,
  output logic [iprc_pkg::ResultW-1:0]  resources_needed,
  output logic                          overflowed
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int TW = iprc_pkg::TimeW;
  localparam int KW = iprc_pkg::KeyW;

  logic [KW-1:0] smem [MAX_ITEMS];
  logic [TW-1:0] bmem [MAX_ITEMS];

  logic [KW-1:0] s_q;
  logic [TW-1:0] b_q;
  logic [KW-1:0] key;
  logic [CW-1:0] cnt;
  logic [CW-1:0] used;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic          ovf;

  logic [CW-1:0] j_m1;
  logic [TW-1:0] st;
  logic [TW-1:0] en;

  assign j_m1 = j - CW'(1);
  assign st   = s_q[KW-1:TW];
  assign en   = s_q[TW-1:0];

  always_ff @(posedge clk) begin
    unique case (cmd)
      iprc_pkg::CMD_INS_MOVE: smem[j[AW-1:0]] <= s_q;
      iprc_pkg::CMD_INS_PUT:  smem[j[AW-1:0]] <= key;
      default: ;
    endcase
    unique case (cmd)
      iprc_pkg::CMD_INS_RD: s_q <= smem[j_m1[AW-1:0]];
      iprc_pkg::CMD_SW_RD:  s_q <= smem[i[AW-1:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (cmd)
      iprc_pkg::CMD_ADD_MOVE: bmem[j[AW-1:0]]    <= b_q;
      iprc_pkg::CMD_ADD_PUT:  bmem[j[AW-1:0]]    <= en;
      iprc_pkg::CMD_REM_MOVE: bmem[j_m1[AW-1:0]] <= b_q;
      iprc_pkg::CMD_REM_PUT:  bmem[j_m1[AW-1:0]] <= en;
      default: ;
    endcase
    unique case (cmd)
      iprc_pkg::CMD_SW_RD:  b_q <= bmem[0];
      iprc_pkg::CMD_ADD_RD: b_q <= bmem[j_m1[AW-1:0]];
      iprc_pkg::CMD_REM_RD: b_q <= bmem[j[AW-1:0]];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd == iprc_pkg::CMD_LOAD) begin
      key <= {iprc_pkg::to_seconds(start_hour, start_minute, start_second),
              iprc_pkg::to_seconds(end_hour, end_minute, end_second)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      ovf  <= 1'b0;
      used <= '0;
      i    <= '0;
      j    <= '0;
    end else begin
      unique case (cmd)
        iprc_pkg::CMD_LOAD: begin
          j <= cnt;
          if (cnt == CW'(MAX_ITEMS)) begin
            ovf <= 1'b1;
          end
        end
        iprc_pkg::CMD_INS_MOVE: j <= j_m1;
        iprc_pkg::CMD_INS_PUT:  cnt <= cnt + CW'(1);
        iprc_pkg::CMD_SW_START: begin
          i    <= '0;
          used <= '0;
        end
        iprc_pkg::CMD_SW_HIT:   j <= CW'(1);
        iprc_pkg::CMD_SW_NEW:   j <= used;
        iprc_pkg::CMD_ADD_MOVE: j <= j_m1;
        iprc_pkg::CMD_ADD_PUT: begin
          used <= used + CW'(1);
          i    <= i + CW'(1);
        end
        iprc_pkg::CMD_REM_MOVE: j <= j + CW'(1);
        iprc_pkg::CMD_REM_PUT:  i <= i + CW'(1);
        iprc_pkg::CMD_CLEAR: begin
          cnt <= '0;
          ovf <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    status.full      = (cnt == CW'(MAX_ITEMS));
    status.j_zero    = (j == '0);
    status.j_eq_used = (j == used);
    status.i_eq_cnt  = (i == cnt);
    status.used_zero = (used == '0);
    status.s_gt_key  = (s_q > key);
    status.b_le_st   = (b_q <= st);
    status.b_gt_en   = (b_q > en);
    status.b_le_en   = (b_q <= en);
  end

  assign resources_needed = iprc_pkg::ResultW'(used);
  assign overflowed       = ovf;

endmodule

// ----- design/iprc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iprc_ctrl
// Sequencer for insertion on load and the greedy sweep at end of set.
// ----------------------------------------------------------------------------
module iprc_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_last,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  iprc_pkg::status_t         status,
  output logic [iprc_pkg::CmdW-1:0] cmd
);

  localparam logic [3:0] IDLE    = 4'd0;
  localparam logic [3:0] INS_CHK = 4'd1;
  localparam logic [3:0] INS_CMP = 4'd2;
  localparam logic [3:0] SW_INIT = 4'd3;
  localparam logic [3:0] SW_CHK  = 4'd4;
  localparam logic [3:0] SW_CMP  = 4'd5;
  localparam logic [3:0] ADD_CHK = 4'd6;
  localparam logic [3:0] ADD_CMP = 4'd7;
  localparam logic [3:0] REM_CHK = 4'd8;
  localparam logic [3:0] REM_CMP = 4'd9;
  localparam logic [3:0] RESULT  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       last_r;
  logic       last_next;
  logic [3:0] after_ins;

  assign in_ready  = (state == IDLE);
  assign out_valid = (state == RESULT);
  assign after_ins = last_r ? SW_INIT : IDLE;

  always_comb begin
    state_next = state;
    last_next  = last_r;
    cmd        = iprc_pkg::CMD_NONE;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd       = iprc_pkg::CMD_LOAD;
          last_next = in_last;
          if (!status.full) begin
            state_next = INS_CHK;
          end else if (in_last) begin
            state_next = SW_INIT;
          end
        end
      end
      INS_CHK: begin
        if (status.j_zero) begin
          cmd        = iprc_pkg::CMD_INS_PUT;
          state_next = after_ins;
        end else begin
          cmd        = iprc_pkg::CMD_INS_RD;
          state_next = INS_CMP;
        end
      end
      INS_CMP: begin
        if (status.s_gt_key) begin
          cmd        = iprc_pkg::CMD_INS_MOVE;
          state_next = INS_CHK;
        end else begin
          cmd        = iprc_pkg::CMD_INS_PUT;
          state_next = after_ins;
        end
      end
      SW_INIT: begin
        cmd        = iprc_pkg::CMD_SW_START;
        state_next = SW_CHK;
      end
      SW_CHK: begin
        if (status.i_eq_cnt) begin
          state_next = RESULT;
        end else begin
          cmd        = iprc_pkg::CMD_SW_RD;
          state_next = SW_CMP;
        end
      end
      SW_CMP: begin
        if (!status.used_zero && status.b_le_st) begin
          cmd        = iprc_pkg::CMD_SW_HIT;
          state_next = REM_CHK;
        end else begin
          cmd        = iprc_pkg::CMD_SW_NEW;
          state_next = ADD_CHK;
        end
      end
      ADD_CHK: begin
        if (status.j_zero) begin
          cmd        = iprc_pkg::CMD_ADD_PUT;
          state_next = SW_CHK;
        end else begin
          cmd        = iprc_pkg::CMD_ADD_RD;
          state_next = ADD_CMP;
        end
      end
      ADD_CMP: begin
        if (status.b_gt_en) begin
          cmd        = iprc_pkg::CMD_ADD_MOVE;
          state_next = ADD_CHK;
        end else begin
          cmd        = iprc_pkg::CMD_ADD_PUT;
          state_next = SW_CHK;
        end
      end
      REM_CHK: begin
        if (status.j_eq_used) begin
          cmd        = iprc_pkg::CMD_REM_PUT;
          state_next = SW_CHK;
        end else begin
          cmd        = iprc_pkg::CMD_REM_RD;
          state_next = REM_CMP;
        end
      end
      REM_CMP: begin
        if (status.b_le_en) begin
          cmd        = iprc_pkg::CMD_REM_MOVE;
          state_next = REM_CHK;
        end else begin
          cmd        = iprc_pkg::CMD_REM_PUT;
          state_next = SW_CHK;
        end
      end
      RESULT: begin
        if (out_ready) begin
          cmd        = iprc_pkg::CMD_CLEAR;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      last_r <= 1'b0;
    end else begin
      state  <= state_next;
      last_r <= last_next;
    end
  end

endmodule

// ----- design/interval_partition_resource_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_partition_resource_count
// Collects a set of intervals and reports the fewest resources needed to
// hold them without overlap (half-open intervals, greedy earliest-free).
//
//   channel  dir  payload
//   s_axis   in   tdata: six time fields, tlast: last_interval
//   m_axis   out  tdata: resources_needed, tuser: overflowed
//
// A loaded item is insertion-sorted into the store, each stored entry it
// passes shifted up by one place. A dropped item is only flagged. The last
// item then starts the sweep over the stored intervals, shifting busy
// entries one place at a time to keep the busy-until list sorted.
// The stores are single-port and insertion shifts entries one by one.
// Reset clears the count and the flag; store contents need no clearing.
// s_tready is low from an accepted item until its work is done, and while a
// result waits on m_tready.
// ----------------------------------------------------------------------------
module interval_partition_resource_count #(
  parameter int MAX_ITEMS = iprc_pkg::MaxItemsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_hour, start_minute, start_second, end_hour, end_minute, end_second
  input  logic [39:0] s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  // resources_needed
  output logic [15:0] m_tdata,
  // overflowed
  output logic        m_tuser
);

  iprc_pkg::status_t             status;
  logic [iprc_pkg::CmdW-1:0]     cmd;
  logic [iprc_pkg::ResultW-1:0]  resources_needed;

  iprc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .cmd       (cmd)
  );

  iprc_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .start_hour       (s_tdata[4:0]),
    .start_minute     (s_tdata[10:5]),
    .start_second     (s_tdata[16:11]),
    .end_hour         (s_tdata[21:17]),
    .end_minute       (s_tdata[27:22]),
    .end_second       (s_tdata[33:28]),
    .status           (status),
    .resources_needed (resources_needed),
    .overflowed       (m_tuser)
  );

  assign m_tdata = {5'd0, resources_needed};

endmodule

// ----- sim/tb_interval_partition_resource_count.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_partition_resource_count
// Self-checking bench for the interval partition resource counter. Interval
// sets are streamed in; a local greedy partition predictor (sort by start,
// reuse the earliest-free resource) computes the expected count and overflow
// flag. Both stream sides throttle at random.
// ----------------------------------------------------------------------------
module tb_interval_partition_resource_count;

  localparam int MaxItems = iprc_pkg::MaxItemsDefault;
  localparam int TimeW    = iprc_pkg::TimeW;
  localparam int KeyW     = iprc_pkg::KeyW;
  localparam int ResultW  = iprc_pkg::ResultW;

  typedef struct {
    logic [4:0] sh;
    logic [5:0] sm;
    logic [5:0] ss;
    logic [4:0] eh;
    logic [5:0] em;
    logic [5:0] es;
    logic       last;
  } interval_t;

  typedef struct {
    logic [ResultW-1:0] count;
    logic               ovf;
  } partition_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;

  interval_t         pending_q[$];
  partition_t        expected_q[$];
  logic [KeyW-1:0]   set_keys[$];
  logic              set_ovf;
  int                errors;
  int                in_gap;
  int                out_stall;
  bit                sent;
  bit                in_burst;
  bit                out_burst;

  interval_partition_resource_count #(.MAX_ITEMS(MaxItems)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TimeW-1:0] secs(logic [4:0] h, logic [5:0] m, logic [5:0] s);
    return TimeW'((int'(h) * 60 + int'(m)) * 60 + int'(s));
  endfunction

  function automatic logic [39:0] pack(interval_t it);
    return {6'd0, it.es, it.em, it.eh, it.ss, it.sm, it.sh};
  endfunction

  function automatic interval_t from_secs(int st, int en, bit last);
    interval_t it;
    it.sh = 5'(st / 3600); it.sm = 6'((st / 60) % 60); it.ss = 6'(st % 60);
    it.eh = 5'(en / 3600); it.em = 6'((en / 60) % 60); it.es = 6'(en % 60);
    it.last = last;
    return it;
  endfunction

  function automatic interval_t raw_interval(bit last);
    interval_t it;
    it.sh = 5'($urandom); it.sm = 6'($urandom); it.ss = 6'($urandom);
    it.eh = 5'($urandom); it.em = 6'($urandom); it.es = 6'($urandom);
    it.last = last;
    return it;
  endfunction

  // greedy partition over the collected set, then clear for the next one
  task automatic close_partition_set();
    int busy[$];
    int used;
    int best;
    int st;
    int en;
    partition_t p;
    set_keys.sort();
    used = 0;
    foreach (set_keys[i]) begin
      st = int'(set_keys[i][KeyW-1:TimeW]);
      en = int'(set_keys[i][TimeW-1:0]);
      best = 0;
      for (int k = 1; k < used; k++) if (busy[k] < busy[best]) best = k;
      if (used > 0 && busy[best] <= st) busy[best] = en;
      else if (used < MaxItems) begin
        busy.push_back(en);
        used++;
      end
    end
    p.count = used[ResultW-1:0];
    p.ovf = set_ovf;
    expected_q.push_back(p);
    set_keys.delete();
    set_ovf = 1'b0;
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input side: accept and predict at the rising edge
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      if (set_keys.size() < MaxItems)
        set_keys.push_back({secs(pending_q[0].sh, pending_q[0].sm, pending_q[0].ss),
                            secs(pending_q[0].eh, pending_q[0].em, pending_q[0].es)});
      else set_ovf = 1'b1;
      if (pending_q[0].last) close_partition_set();
      void'(pending_q.pop_front());
      sent = 1'b1;
      in_gap = in_burst ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    end
  end

  always @(negedge clk) begin
    bit vld;
    vld = s_tvalid && !sent;
    sent = 1'b0;
    if (!rst && !vld) begin
      if (in_gap > 0) in_gap--;
      else if (pending_q.size() > 0) begin
        s_tdata <= pack(pending_q[0]);
        s_tlast <= pending_q[0].last;
        vld = 1'b1;
      end
    end
    s_tvalid <= vld;
  end

  // output side
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        errors++;
      end else begin
        if (m_tdata !== {5'd0, expected_q[0].count})
          report("resources_needed", m_tdata, {5'd0, expected_q[0].count});
        if (m_tuser !== expected_q[0].ovf)
          report("overflowed", {15'd0, m_tuser}, {15'd0, expected_q[0].ovf});
        void'(expected_q.pop_front());
      end
      out_stall = out_burst ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
    end
  end

  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      m_tready <= 1'b0;
    end else m_tready <= 1'b1;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int n;
    int total;
    int base;
    int len;
    int st;
    interval_t it;
    errors = 0; in_gap = 0; out_stall = 0; sent = 0;
    in_burst = 0; out_burst = 0; set_ovf = 0;
    s_tvalid = 0; s_tdata = '0; s_tlast = 0; m_tready = 0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // single interval, all-zero and all-ones fields
    pending_q.push_back(from_secs(0, 0, 1));
    it.sh = '1; it.sm = '1; it.ss = '1; it.eh = '1; it.em = '1; it.es = '1; it.last = 1;
    pending_q.push_back(it);
    // touching intervals reuse one resource; identical ones need two
    pending_q.push_back(from_secs(100, 200, 0));
    pending_q.push_back(from_secs(200, 300, 0));
    pending_q.push_back(from_secs(300, 400, 1));
    pending_q.push_back(from_secs(500, 600, 0));
    pending_q.push_back(from_secs(500, 600, 1));
    // end before start, mixed with nested and overlapping intervals
    pending_q.push_back(from_secs(86399, 10, 0));
    pending_q.push_back(from_secs(50, 40, 0));
    pending_q.push_back(from_secs(0, 86399, 0));
    pending_q.push_back(from_secs(3600, 7200, 0));
    pending_q.push_back(from_secs(5000, 9000, 1));
    // out-of-range fields
    pending_q.push_back(raw_interval(0));
    pending_q.push_back(raw_interval(0));
    pending_q.push_back(raw_interval(1));
    // set beyond capacity, ascending so the sweep stays short
    for (int i = 0; i < MaxItems + 2; i++)
      pending_q.push_back(from_secs(i, i + 1, i == MaxItems + 1));
    pending_q.push_back(from_secs(7, 8, 1));

    total = pending_q.size();
    while (total < 1200) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      base = $urandom_range(0, 80000);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) it = raw_interval(i == n - 1);
        else begin
          len = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 3000);
          st = base + $urandom_range(0, 3000);
          it = from_secs(st, (st + len) % 86400, i == n - 1);
        end
        pending_q.push_back(it);
      end
      total += n;
    end

    wait (pending_q.size() == 0 && !s_tvalid);
    wait (expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/iprc_pkg.sv
design/iprc_datapath.sv
design/iprc_ctrl.sv
design/interval_partition_resource_count.sv
sim/tb_interval_partition_resource_count.sv
